// ===== hdl/e2b_pkg.sv =====
// Shared types, constants and the CORDIC arctangent table for the Euler-to-basis block.
// No dependencies.
package e2b_pkg;

    localparam int ANGLE_W = 32;
    localparam int OUT_W   = 18;
    localparam int TRIG_W  = 34;   // Q30 lane width with headroom for CORDIC gain
    localparam int ATAN_N  = 24;

    localparam logic [1:0] AXIS_RIGHT   = 2'd0;
    localparam logic [1:0] AXIS_UP      = 2'd1;
    localparam logic [1:0] AXIS_FORWARD = 2'd2;
    localparam logic [1:0] AXIS_NONE    = 2'd3;

    // Degree phase division: the dividend is biased by 45 * 2^40 so that it is never
    // negative; the bias adds 2^40 to the quotient, which vanishes modulo 2^32.
    localparam logic [63:0] DEG_BIAS    = 64'd45 << 40;
    // Reciprocal of 45 for dividends below 2^29: ceil(2^35 / 45), exact in that range.
    localparam logic [29:0] DIV45_MUL   = 30'd763549742;
    localparam int          DIV45_SHIFT = 35;

    typedef logic signed [TRIG_W-1:0] trig_t;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] r;
        begin
            case (i)
                5'd0:  r = 32'h20000000;
                5'd1:  r = 32'h12E4051E;
                5'd2:  r = 32'h09FB385B;
                5'd3:  r = 32'h051111D4;
                5'd4:  r = 32'h028B0D43;
                5'd5:  r = 32'h0145D7E1;
                5'd6:  r = 32'h00A2F61E;
                5'd7:  r = 32'h00517C55;
                5'd8:  r = 32'h0028BE53;
                5'd9:  r = 32'h00145F2F;
                5'd10: r = 32'h000A2F98;
                5'd11: r = 32'h000517CC;
                5'd12: r = 32'h00028BE6;
                5'd13: r = 32'h000145F3;
                5'd14: r = 32'h0000A2FA;
                5'd15: r = 32'h0000517D;
                5'd16: r = 32'h000028BE;
                5'd17: r = 32'h0000145F;
                5'd18: r = 32'h00000A30;
                5'd19: r = 32'h00000518;
                5'd20: r = 32'h0000028C;
                5'd21: r = 32'h00000146;
                5'd22: r = 32'h000000A3;
                5'd23: r = 32'h00000051;
                default: r = 32'h0;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== hdl/e2b_trig_lane.sv =====
// One pipelined trigonometry lane: angle to phase, quadrant fold, CORDIC, unfold.
// Depends on e2b_pkg.
module e2b_trig_lane #(
    parameter int ITER = 16
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic signed [31:0]            angle,
    input  logic                          in_degrees,
    input  logic                          negate,
    output e2b_pkg::trig_t                cos_out,
    output e2b_pkg::trig_t                sin_out
);
    import e2b_pkg::*;

    localparam int N  = (ITER < 8) ? 8 : ((ITER > 24) ? 24 : ITER);
    localparam longint KV = 64'd652032874 + ((64'd434688583 + (64'd1 << (2*N-1))) >> (2*N));

    // Stage A: degrees need floor((a * 8192 + 22) / 45), so a biased nonnegative
    // dividend is formed; radians take the product with 683565276.
    logic [63:0]        deg_word;
    logic signed [63:0] prod_reg;
    logic               deg_a_reg, neg_a_reg;
    assign deg_word = ({{32{angle[31]}}, angle} << 13) + 64'd22 + DEG_BIAS;
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg  <= in_degrees ? $signed(deg_word)
                                    : ($signed({{32{angle[31]}}, angle}) * 64'sd683565276);
            deg_a_reg <= in_degrees;
            neg_a_reg <= negate;
        end
    end

    // Stage B: radian phase, and the reciprocal product for the upper dividend half.
    logic [31:0] ph_rad;
    assign ph_rad = 32'((prod_reg + 64'sd32768) >>> 16);

    logic [52:0] hq_prod_reg;
    logic [22:0] hi_b_reg, lo_b_reg;
    logic [31:0] rad_b_reg;
    logic        deg_b_reg, neg_b_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            hq_prod_reg <= 53'(prod_reg[45:23]) * 53'(DIV45_MUL);
            hi_b_reg    <= prod_reg[45:23];
            lo_b_reg    <= prod_reg[22:0];
            rad_b_reg   <= ph_rad;
            deg_b_reg   <= deg_a_reg;
            neg_b_reg   <= neg_a_reg;
        end
    end

    // Stage C: upper quotient and remainder; the remainder heads the lower dividend.
    logic [17:0] qh_b;
    logic [22:0] rh_b;
    assign qh_b = hq_prod_reg[52:DIV45_SHIFT];
    assign rh_b = hi_b_reg - 23'(qh_b) * 23'd45;

    logic [8:0]  qh_c_reg;
    logic [28:0] x_c_reg;
    logic [31:0] rad_c_reg;
    logic        deg_c_reg, neg_c_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            qh_c_reg  <= qh_b[8:0];
            x_c_reg   <= {rh_b[5:0], lo_b_reg};
            rad_c_reg <= rad_b_reg;
            deg_c_reg <= deg_b_reg;
            neg_c_reg <= neg_b_reg;
        end
    end

    // Stage D: reciprocal product for the lower dividend.
    logic [58:0] lq_prod_reg;
    logic [8:0]  qh_d_reg;
    logic [31:0] rad_d_reg;
    logic        deg_d_reg, neg_d_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            lq_prod_reg <= 59'(x_c_reg) * 59'(DIV45_MUL);
            qh_d_reg    <= qh_c_reg;
            rad_d_reg   <= rad_c_reg;
            deg_d_reg   <= deg_c_reg;
            neg_d_reg   <= neg_c_reg;
        end
    end

    // Stage E: assemble the degree phase modulo 2^32, select the unit, negate if asked.
    logic [31:0] ph_deg, ph;
    assign ph_deg = {qh_d_reg, 23'd0} + 32'(lq_prod_reg[58:DIV45_SHIFT]);
    assign ph     = deg_d_reg ? ph_deg : rad_d_reg;

    logic [31:0] ph_reg;
    always_ff @(posedge aclk) begin
        if (en) ph_reg <= neg_d_reg ? (32'd0 - ph) : ph;
    end

    // CORDIC stages; stage 0 holds the folded residual.
    trig_t       x_s [0:N];
    trig_t       y_s [0:N];
    logic signed [33:0] z_s [0:N];
    logic [1:0]  q_s [0:N];

    logic [1:0] q0;
    assign q0 = 2'((({1'b0, ph_reg} + 33'h20000000) >> 30) & 33'd3);
    assign x_s[0] = trig_t'(KV);
    assign y_s[0] = '0;
    assign z_s[0] = 34'($signed(ph_reg - {q0, 30'd0}));
    assign q_s[0] = q0;

    for (genvar i = 0; i < N; i++) begin : g_it
        trig_t x_r, y_r;
        logic signed [33:0] z_r;
        logic [1:0] q_r;
        always_ff @(posedge aclk) begin
            if (en) begin
                if (!z_s[i][33]) begin
                    x_r <= x_s[i] - (y_s[i] >>> i);
                    y_r <= y_s[i] + (x_s[i] >>> i);
                    z_r <= z_s[i] - $signed({2'b00, atan_turn(5'(i))});
                end else begin
                    x_r <= x_s[i] + (y_s[i] >>> i);
                    y_r <= y_s[i] - (x_s[i] >>> i);
                    z_r <= z_s[i] + $signed({2'b00, atan_turn(5'(i))});
                end
                q_r <= q_s[i];
            end
        end
        assign x_s[i+1] = x_r;
        assign y_s[i+1] = y_r;
        assign z_s[i+1] = z_r;
        assign q_s[i+1] = q_r;
    end

    // Quadrant restore.
    always_comb begin
        case (q_s[N])
            2'd0: begin cos_out = x_s[N];  sin_out = y_s[N];  end
            2'd1: begin cos_out = -y_s[N]; sin_out = x_s[N];  end
            2'd2: begin cos_out = -x_s[N]; sin_out = -y_s[N]; end
            default: begin cos_out = y_s[N]; sin_out = -x_s[N]; end
        endcase
    end
endmodule

// ===== hdl/e2b_row_merge.sv =====
// Merge stage: combines the three lanes' cosines and sines into one matrix row.
// Depends on e2b_pkg.
module e2b_row_merge (
    input  logic            aclk,
    input  logic            en,
    input  e2b_pkg::trig_t  cx, sx, cy, sy, cz, sz,
    input  logic [1:0]      axis,
    output logic signed [17:0] out_x,
    output logic signed [17:0] out_y,
    output logic signed [17:0] out_z
);
    import e2b_pkg::*;

    function automatic logic signed [17:0] to_q16(input logic signed [69:0] v);
        logic signed [69:0] r;
        begin
            r = (v + (70'sd1 <<< 43)) >>> 44;
            if (r > 70'sd131071) return 18'sd131071;
            if (r < -70'sd131072) return -18'sd131072;
            return 18'(r);
        end
    endfunction

    // Stage 1: the first-level products.
    logic signed [67:0] p_sxsy_reg, p_cxsy_reg, p_cycz_reg, p_cysz_reg, p_sxcy_reg, p_cxcy_reg;
    trig_t c1x, s1x, c1z, s1z, s1y;
    logic [1:0] ax1;
    always_ff @(posedge aclk) begin
        if (en) begin
            p_sxsy_reg <= 68'(sx * sy);
            p_cxsy_reg <= 68'(cx * sy);
            p_cycz_reg <= 68'(cy * cz);
            p_cysz_reg <= 68'(cy * sz);
            p_sxcy_reg <= 68'(sx * cy);
            p_cxcy_reg <= 68'(cx * cy);
            c1x <= cx; s1x <= sx; c1z <= cz; s1z <= sz; s1y <= sy; ax1 <= axis;
        end
    end

    // Stage 2: round the shared term to Q30 and pick operands by row.
    trig_t a_r;
    assign a_r = trig_t'((((ax1 == AXIS_UP) ? p_sxsy_reg : p_cxsy_reg)
                          + (68'sd1 <<< 29)) >>> 30);
    trig_t a2, b2, cz2, sz2;
    logic signed [67:0] e2_reg, d0_reg, d1_reg, e0_reg;
    logic [1:0] ax2;
    logic signed [67:0] m_cxsz, m_cxcz, m_sxsz, m_sxcz;
    always_ff @(posedge aclk) begin
        if (en) begin
            a2 <= a_r; cz2 <= c1z; sz2 <= s1z; ax2 <= ax1;
            m_cxsz <= 68'(c1x * s1z); m_cxcz <= 68'(c1x * c1z);
            m_sxsz <= 68'(s1x * s1z); m_sxcz <= 68'(s1x * c1z);
            d0_reg <= p_cycz_reg; d1_reg <= p_cysz_reg;
            unique case (ax1)
                AXIS_RIGHT: e2_reg <= -(68'(s1y) <<< 30);
                AXIS_UP:    e2_reg <= p_sxcy_reg;
                default:    e2_reg <= p_cxcy_reg;
            endcase
        end
    end

    // Stage 3: second-level products and sums.
    logic signed [69:0] m0, m1, m2;
    logic signed [67:0] acz, asz;
    assign acz = 68'(a2 * cz2);
    assign asz = 68'(a2 * sz2);
    always_comb begin
        m2 = 70'(e2_reg);
        case (ax2)
            AXIS_RIGHT: begin m0 = 70'(d0_reg); m1 = 70'(d1_reg); end
            AXIS_UP:    begin m0 = 70'(acz) - 70'(m_cxsz); m1 = 70'(asz) + 70'(m_cxcz); end
            default:    begin m0 = 70'(acz) + 70'(m_sxsz); m1 = 70'(asz) - 70'(m_sxcz); end
        endcase
        if (ax2 == AXIS_NONE) begin m0 = '0; m1 = '0; m2 = '0; end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            out_x <= to_q16(m2);
            out_y <= to_q16(m1);
            out_z <= to_q16(m0);
        end
    end
endmodule

// ===== hdl/euler_to_basis_axis_unit.sv =====
// Top level of the Euler-to-basis block: three trig lanes, a merge stage and a stall pipeline.
// Depends on e2b_pkg, e2b_trig_lane and e2b_row_merge.
//
// Usage: s_axis carries three Q16.16 angles, the row index and the unit flag; m_axis
// returns the chosen row of Rx*Ry*Rz reversed, as three Q2.16 values.
// Throughput: one transfer per cycle while the output is not stalled. N is
// TRIG_ITERATIONS clamped to [8, 24]; each lane spends five stages turning the
// angle into a phase, then N CORDIC stages, and the merge adds three.
// The whole pipeline advances as one; when m_tready is low and the output holds a
// result, the pipeline freezes and s_tready drops in the same cycle.
// Reset clears all valid flags; no item is in flight afterward. Index three gives zeros.
module euler_to_basis_axis_unit #(
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // angle_x[31:0], angle_y[63:32], angle_z[95:64], axis_index[97:96], pad
    input  logic [103:0] s_tdata,
    // in_degrees[0]
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // axis_out_x[17:0], axis_out_y[35:18], axis_out_z[53:36], pad
    output logic [55:0]  m_tdata
);
    import e2b_pkg::*;

    localparam int N   = (TRIG_ITERATIONS < 8) ? 8 : ((TRIG_ITERATIONS > 24) ? 24 : TRIG_ITERATIONS);
    localparam int LAT = N + 7;

    logic en;
    logic [LAT-1:0] vld_reg;
    logic [1:0]     ax_reg [0:N+4];

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            m_tvalid <= 1'b0;
        end else if (en) begin
            vld_reg  <= {vld_reg[LAT-2:0], s_tvalid};
            m_tvalid <= vld_reg[LAT-1];
        end
    end

    // Row index travels beside the lanes.
    always_ff @(posedge aclk) begin
        if (en) begin
            ax_reg[0] <= s_tdata[97:96];
            for (int k = 1; k <= N + 4; k++) ax_reg[k] <= ax_reg[k-1];
        end
    end

    trig_t cx, sx, cy, sy, cz, sz;
    e2b_trig_lane #(.ITER(N)) u_lx (.aclk, .en, .angle(s_tdata[31:0]),  .in_degrees(s_tuser),
        .negate(1'b1), .cos_out(cx), .sin_out(sx));
    e2b_trig_lane #(.ITER(N)) u_ly (.aclk, .en, .angle(s_tdata[63:32]), .in_degrees(s_tuser),
        .negate(1'b0), .cos_out(cy), .sin_out(sy));
    e2b_trig_lane #(.ITER(N)) u_lz (.aclk, .en, .angle(s_tdata[95:64]), .in_degrees(s_tuser),
        .negate(1'b1), .cos_out(cz), .sin_out(sz));

    logic signed [17:0] ox, oy, oz;
    e2b_row_merge u_merge (.aclk, .en, .cx, .sx, .cy, .sy, .cz, .sz,
        .axis(ax_reg[N+4]), .out_x(ox), .out_y(oy), .out_z(oz));

    assign m_tdata = {2'b00, oz, oy, ox};
endmodule

// ===== hdl/e2b_checker.sv =====
// Port-level checker for the Euler-to-basis block, bound to the top level.
// Depends only on the top level's ports.
module e2b_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);
    // A stalled result holds its data.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result changed");
    // Input is open whenever output is free.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready) else $error("ready dropped");
    // Input is closed while output stalls.
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready) else $error("ready while stalled");
    // Pad bits stay zero.
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[55:54] == 2'b00) else $error("pad set");
endmodule

bind euler_to_basis_axis_unit e2b_checker u_chk (.aclk, .aresetn, .s_tready, .m_tvalid,
    .m_tready, .m_tdata);
